@@ hw/rtl/dnrs_pkg.sv @@
// shared constants and types for the directional nearest rectangle selector
`timescale 1ns / 1ps
package dnrs_pkg;

  localparam int COORD_W   = 16;
  localparam int EDGE_W    = 19;  // signed edge position, coordinate plus size
  localparam int DIFF_W    = 20;  // signed difference between edges
  localparam int SUM_W     = 22;  // signed miss weight sum
  localparam int WEIGHT_W  = 21;
  localparam int OVERLAP_W = 19;
  localparam int INDEX_W   = 8;
  localparam int CFG_IDX_W = 3;

  localparam int MAX_CANDIDATES_DEF = 256;

  localparam logic [WEIGHT_W-1:0] WEIGHT_INIT  = WEIGHT_W'(999999);
  localparam logic [SUM_W-1:0]    MISS_PENALTY = SUM_W'(100000);

  typedef enum logic [1:0] {
    DIR_UP    = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_RIGHT = 2'd3
  } dir_t;

  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REF_X      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REF_Y      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REF_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REF_HEIGHT = 3'd4;

endpackage

@@ hw/rtl/directional_nearest_rect_select_core.sv @@
// top level: streaming nearest rectangle search in one of four directions
`timescale 1ns / 1ps
// path: a beat taken on s_* is held in the input register, which the judge stage reads; the result of a
//   last beat is registered in the result register that drives m_*, and a blocked result register stalls it
// throughput: one candidate per cycle while no last beat waits on a blocked result register, set by the single judge
//   stage that compares each candidate against the running best in one pass
// reset (rst, synchronous, active high) clears registers to zero, direction to up, the
//   search state to its initial best weight, and empties the input and result registers
module directional_nearest_rect_select_core #(
  parameter int MAX_CANDIDATES = dnrs_pkg::MAX_CANDIDATES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // candidate stream
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [63:0]                    s_tdata,  // cand_x, cand_y, cand_width, cand_height
  input  logic                           s_tuser,  // skip
  input  logic                           s_tlast,  // last candidate of the query
  // result stream
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [dnrs_pkg::INDEX_W-1:0]   m_tdata,  // winner_index
  output logic                           m_tuser,  // found
  // configuration writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dnrs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dnrs_pkg::COORD_W-1:0]   cfg_data
);
  import dnrs_pkg::*;

  localparam int CNT_W = $clog2(MAX_CANDIDATES + 1);
  localparam int EXT_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [COORD_W-1:0]        w;
    logic [COORD_W-1:0]        h;
    logic                      skip;
    logic                      last;
  } cand_t;

  // configuration registers
  dir_t                      direction;
  logic signed [COORD_W-1:0] ref_x;
  logic signed [COORD_W-1:0] ref_y;
  logic [COORD_W-1:0]        ref_width;
  logic [COORD_W-1:0]        ref_height;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      direction  <= DIR_UP;
      ref_x      <= '0;
      ref_y      <= '0;
      ref_width  <= '0;
      ref_height <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DIRECTION:  direction  <= dir_t'(cfg_data[1:0]);
        REG_REF_X:      ref_x      <= cfg_data;
        REG_REF_Y:      ref_y      <= cfg_data;
        REG_REF_WIDTH:  ref_width  <= cfg_data;
        REG_REF_HEIGHT: ref_height <= cfg_data;
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  // input register
  cand_t cand;
  logic  cand_valid;
  logic  advance;

  // the judge stage stalls only when it holds a last beat and the result register is blocked
  assign advance  = !(cand_valid && cand.last && m_tvalid && !m_tready);
  assign s_tready = !cand_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cand_valid <= 1'b0;
    end else if (s_tready) begin
      cand_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      cand.x    <= s_tdata[15:0];
      cand.y    <= s_tdata[31:16];
      cand.w    <= s_tdata[47:32];
      cand.h    <= s_tdata[63:48];
      cand.skip <= s_tuser;
      cand.last <= s_tlast;
    end
  end

  // search state
  logic [WEIGHT_W-1:0]  best_weight,  best_weight_next;
  logic [OVERLAP_W-1:0] best_overlap, best_overlap_next;
  logic                 have_winner,  have_winner_next;
  logic [INDEX_W-1:0]   best_index,   best_index_next;
  logic [CNT_W-1:0]     item_count,   item_count_next;

  // edges of both rectangles
  logic signed [EDGE_W-1:0] r_top, r_bot, r_left, r_right;
  logic signed [EDGE_W-1:0] c_top, c_bot, c_left, c_right;
  logic signed [EDGE_W-1:0] edge_pos, oedge_pos, upper, lower, oupper, olower;
  logic signed [DIFF_W-1:0] gap, d_upper, d_lower, ov;
  logic [DIFF_W-1:0]        abs_upper, abs_lower;
  logic signed [SUM_W-1:0]  miss_w;
  logic                     in_range, judged, miss;
  logic [EXT_W-1:0]         pos_ext;

  always_comb begin
    r_top   = EDGE_W'(ref_y);
    r_bot   = r_top + EDGE_W'($signed({1'b0, ref_height}));
    r_left  = EDGE_W'(ref_x);
    r_right = r_left + EDGE_W'($signed({1'b0, ref_width}));
    c_top   = EDGE_W'(cand.y);
    c_bot   = c_top + EDGE_W'($signed({1'b0, cand.h}));
    c_left  = EDGE_W'(cand.x);
    c_right = c_left + EDGE_W'($signed({1'b0, cand.w}));

    // leading edge pair per direction
    unique case (direction)
      DIR_UP:    begin edge_pos = c_bot;  oedge_pos = r_bot;   end
      DIR_DOWN:  begin edge_pos = r_top;  oedge_pos = c_top;   end
      DIR_LEFT:  begin edge_pos = c_right; oedge_pos = r_right; end
      default:   begin edge_pos = r_left; oedge_pos = c_left;  end
    endcase

    // side span: horizontal for up and down, vertical for left and right
    if (direction == DIR_UP || direction == DIR_DOWN) begin
      upper = r_left; lower = r_right; oupper = c_left; olower = c_right;
    end else begin
      upper = r_top;  lower = r_bot;   oupper = c_top;  olower = c_bot;
    end

    gap       = DIFF_W'(oedge_pos) - DIFF_W'(edge_pos);
    d_upper   = DIFF_W'(upper) - DIFF_W'(oupper);
    d_lower   = DIFF_W'(lower) - DIFF_W'(olower);
    abs_upper = d_upper[DIFF_W-1] ? DIFF_W'(-d_upper) : DIFF_W'(d_upper);
    abs_lower = d_lower[DIFF_W-1] ? DIFF_W'(-d_lower) : DIFF_W'(d_lower);
    miss_w    = MISS_PENALTY + SUM_W'(gap) + SUM_W'($signed({1'b0, abs_upper}))
              + SUM_W'($signed({1'b0, abs_lower}));
    ov        = ((lower < olower) ? DIFF_W'(lower) : DIFF_W'(olower))
              - ((upper > oupper) ? DIFF_W'(upper) : DIFF_W'(oupper));
    miss      = (olower <= upper) || (oupper >= lower);

    in_range = item_count < CNT_W'(MAX_CANDIDATES);
    judged   = in_range && !cand.skip && !gap[DIFF_W-1];
    pos_ext  = EXT_W'(item_count);

    best_weight_next  = best_weight;
    best_overlap_next = best_overlap;
    have_winner_next  = have_winner;
    best_index_next   = best_index;
    item_count_next   = in_range ? item_count + CNT_W'(1) : item_count;

    if (judged) begin
      if (miss) begin
        // outside the span: penalized weight, overlap counts as none
        if (miss_w < SUM_W'($signed({1'b0, best_weight}))) begin
          have_winner_next  = 1'b1;
          best_index_next   = pos_ext[INDEX_W-1:0];
          best_overlap_next = '0;
          best_weight_next  = miss_w[WEIGHT_W-1:0];
        end
      end else if (WEIGHT_W'(gap[EDGE_W-1:0]) < best_weight) begin
        have_winner_next  = 1'b1;
        best_index_next   = pos_ext[INDEX_W-1:0];
        best_weight_next  = WEIGHT_W'(gap[EDGE_W-1:0]);
        best_overlap_next = ov[OVERLAP_W-1:0];
      end else if (have_winner && WEIGHT_W'(gap[EDGE_W-1:0]) == best_weight
                   && ov[OVERLAP_W-1:0] > best_overlap) begin
        // equal gap, larger overlap wins the tie
        best_index_next   = pos_ext[INDEX_W-1:0];
        best_overlap_next = ov[OVERLAP_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_weight  <= WEIGHT_INIT;
      best_overlap <= '0;
      have_winner  <= 1'b0;
      best_index   <= '0;
      item_count   <= '0;
    end else if (cand_valid && advance) begin
      if (cand.last) begin
        // query closes: start over for the next one
        best_weight  <= WEIGHT_INIT;
        best_overlap <= '0;
        have_winner  <= 1'b0;
        best_index   <= '0;
        item_count   <= '0;
      end else begin
        best_weight  <= best_weight_next;
        best_overlap <= best_overlap_next;
        have_winner  <= have_winner_next;
        best_index   <= best_index_next;
        item_count   <= item_count_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cand_valid && advance && cand.last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cand_valid && advance && cand.last) begin
      m_tuser <= have_winner_next;
      m_tdata <= have_winner_next ? best_index_next : '0;
    end
  end

endmodule

@@ sim/tb_directional_nearest_rect_select_core.sv @@
// testbench: directed and random candidate streams, each result checked against a behavioral search model
`timescale 1ns / 1ps
module tb_directional_nearest_rect_select_core;
  import dnrs_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int HOLD_CYCLES   = 300;
  localparam int LONG_QUERY    = 270;   // runs past the candidate capacity
  localparam int MISS_WEIGHT   = 100000;
  localparam int OPEN_WEIGHT   = 999999;
  localparam int SHOWN_ERRORS  = 10;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [15:0]        w;
    logic [15:0]        h;
    bit                 skip;
    bit                 last;
  } cand_t;

  typedef struct {
    bit         found;
    logic [7:0] index;
  } verdict_t;

  // behavioral nearest rectangle search plus the queue of verdicts still owed by the block
  class winner_board;
    dir_t       dir;
    int         ref_x, ref_y, ref_w, ref_h;
    int         best_weight, best_overlap, best_pos, position;
    bit         have_winner;
    verdict_t   winners_due[$];
    int         failures;

    function new();
      dir = DIR_UP;
      ref_x = 0;
      ref_y = 0;
      ref_w = 0;
      ref_h = 0;
      failures = 0;
      clear_search();
    endfunction

    function void clear_search();
      best_weight = OPEN_WEIGHT;
      best_overlap = 0;
      have_winner = 0;
      best_pos = 0;
      position = 0;
    endfunction

    function int magnitude(int v);
      return (v < 0) ? -v : v;
    endfunction

    function int pending();
      return winners_due.size();
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
      case (idx)
        REG_DIRECTION:  dir = dir_t'(data[1:0]);
        REG_REF_X:      ref_x = $signed(data);
        REG_REF_Y:      ref_y = $signed(data);
        REG_REF_WIDTH:  ref_w = data;
        REG_REF_HEIGHT: ref_h = data;
        default: ;
      endcase
    endfunction

    // weigh one eligible candidate against the best so far
    function void judge(cand_t c, int pos);
      int top, bottom, left, right;
      int otop, obottom, oleft, oright;
      int lead, olead, upper, lower, oupper, olower, gap, w, ov;
      top = ref_y;
      bottom = ref_y + ref_h;
      left = ref_x;
      right = ref_x + ref_w;
      otop = c.y;
      obottom = otop + c.h;
      oleft = c.x;
      oright = oleft + c.w;
      case (dir)
        DIR_UP: begin
          lead = obottom;
          olead = bottom;
        end
        DIR_DOWN: begin
          lead = top;
          olead = otop;
        end
        DIR_LEFT: begin
          lead = oright;
          olead = right;
        end
        default: begin
          lead = left;
          olead = oleft;
        end
      endcase
      if (dir == DIR_UP || dir == DIR_DOWN) begin
        upper = left;
        lower = right;
        oupper = oleft;
        olower = oright;
      end else begin
        upper = top;
        lower = bottom;
        oupper = otop;
        olower = obottom;
      end
      // behind the leading edge
      if (olead < lead) return;
      gap = olead - lead;
      if (olower <= upper || oupper >= lower) begin
        // off to the side: heavy penalty plus both side offsets
        w = MISS_WEIGHT + gap + magnitude(upper - oupper) + magnitude(lower - olower);
        if (w < best_weight) begin
          have_winner = 1;
          best_pos = pos;
          best_overlap = 0;
          best_weight = w;
        end
      end else begin
        ov = ((lower < olower) ? lower : olower) - ((upper > oupper) ? upper : oupper);
        if (gap < best_weight) begin
          have_winner = 1;
          best_pos = pos;
          best_weight = gap;
          best_overlap = ov;
        end else if (have_winner && gap == best_weight && ov > best_overlap) begin
          // equal gap: larger overlap takes it
          best_pos = pos;
          best_overlap = ov;
        end
      end
    endfunction

    function void note_candidate(cand_t c);
      verdict_t v;
      // past capacity the position saturates and the candidate counts as skipped
      if (position < MAX_CANDIDATES_DEF) begin
        if (!c.skip) judge(c, position);
        position++;
      end
      if (c.last) begin
        v.found = have_winner;
        v.index = have_winner ? best_pos[7:0] : 8'd0;
        winners_due.insert(winners_due.size(), v);
        clear_search();
      end
    endfunction

    function void check_winner(bit found, logic [7:0] index);
      verdict_t v;
      if (winners_due.size() == 0) begin
        failures++;
        if (failures <= SHOWN_ERRORS)
          $display("unexpected result beat: found=%0d index=%0d", found, index);
        return;
      end
      v = winners_due.pop_front();
      if (found !== v.found || index !== v.index) begin
        failures++;
        if (failures <= SHOWN_ERRORS)
          $display("result mismatch: expected found=%0d index=%0d, got found=%0d index=%0d",
                   v.found, v.index, found, index);
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [63:0]          s_tdata = '0;
  logic                 s_tuser = 1'b0;
  logic                 s_tlast = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [INDEX_W-1:0]   m_tdata;
  logic                 m_tuser;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COORD_W-1:0]   cfg_data = '0;

  winner_board board = new();

  // reference the stimulus is aimed at, kept apart from the board's copy
  dir_t gen_dir = DIR_UP;
  int   gen_x = 0, gen_y = 0, gen_w = 0, gen_h = 0;
  int   sender_idle_pct = 0;
  int   stall_pct = 0;
  int   hold_requests = 0;
  int   hold_served = 0;
  int   hold_left = 0;
  int   cycles = 0;

  directional_nearest_rect_select_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result side: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // watch every handshake and feed the board
  always @(posedge clk) begin
    cand_t seen;
    if (!rst) begin
      if (cfg_valid && cfg_ready) board.set_reg(cfg_index, cfg_data);
      if (s_tvalid && s_tready) begin
        seen.x = s_tdata[15:0];
        seen.y = s_tdata[31:16];
        seen.w = s_tdata[47:32];
        seen.h = s_tdata[63:48];
        seen.skip = s_tuser;
        seen.last = s_tlast;
        board.note_candidate(seen);
      end
      if (m_tvalid && m_tready) board.check_winner(m_tuser, m_tdata);
    end
  end

  function automatic cand_t cand(int x, int y, int w, int h, bit skip, bit last);
    cand_t c;
    c.x = 16'(x);
    c.y = 16'(y);
    c.w = 16'(w);
    c.h = 16'(h);
    c.skip = skip;
    c.last = last;
    return c;
  endfunction

  // mostly candidates clustered around the reference so gaps, overlaps and ties show up
  function automatic cand_t random_candidate(bit last, bit wild);
    cand_t c;
    if (wild || $urandom_range(99) < 15) begin
      c.x = 16'($urandom);
      c.y = 16'($urandom);
      c.w = 16'($urandom);
      c.h = 16'($urandom);
    end else begin
      c.x = 16'(gen_x + $urandom_range(60) - 30);
      c.y = 16'(gen_y + $urandom_range(60) - 30);
      c.w = ($urandom_range(3) == 0) ? 16'(gen_w + $urandom_range(6) - 3)
                                     : 16'($urandom_range(24));
      c.h = ($urandom_range(3) == 0) ? 16'(gen_h + $urandom_range(6) - 3)
                                     : 16'($urandom_range(24));
    end
    c.skip = ($urandom_range(9) == 0);
    c.last = last;
    return c;
  endfunction

  task automatic send_candidate(cand_t c);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {c.h, c.w, c.y, c.x};
    s_tuser <= c.skip;
    s_tlast <= c.last;
    do @(posedge clk); while (!s_tready);
  endtask

  // stop offering, wait out every owed result and the pipeline tail
  task automatic settle_block();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic program_reference(dir_t dir, int rx, int ry, int rw, int rh);
    settle_block();
    write_reg(REG_DIRECTION, 16'(dir));
    write_reg(REG_REF_X, 16'(rx));
    write_reg(REG_REF_Y, 16'(ry));
    write_reg(REG_REF_WIDTH, 16'(rw));
    write_reg(REG_REF_HEIGHT, 16'(rh));
    cfg_valid <= 1'b0;
    gen_dir = dir;
    gen_x = rx;
    gen_y = ry;
    gen_w = rw;
    gen_h = rh;
  endtask

  // one query past capacity: a shifted copy of the reference, overlapping it less, at the last counted
  // position, then exact copies that would beat it if they were still counted
  task automatic run_long_query();
    cand_t c;
    int pos;
    send_candidate(random_candidate(1'b1, 1'b0));  // close whatever query is open
    for (pos = 0; pos < LONG_QUERY; pos++) begin
      if (pos < MAX_CANDIDATES_DEF - 1) begin
        c = random_candidate(1'b0, 1'b1);
      end else begin
        c = cand(gen_x, gen_y, gen_w, gen_h, 1'b0, pos == LONG_QUERY - 1);
        if (pos == MAX_CANDIDATES_DEF - 1) begin
          if (gen_dir == DIR_UP || gen_dir == DIR_DOWN) c.x = 16'(gen_x + 1);
          else c.y = 16'(gen_y + 1);
        end
      end
      send_candidate(c);
    end
  endtask

  // a phase may stop inside an open query, so the next settings judge its remainder
  task automatic run_phase(dir_t dir, int rx, int ry, int rw, int rh, int idle, int stall,
                           int items, bit long_query, bit hold);
    int sent;
    program_reference(dir, rx, ry, rw, rh);
    sender_idle_pct = idle;
    stall_pct = stall;
    if (hold) hold_requests++;
    if (long_query) run_long_query();
    for (sent = 0; sent < items; sent++)
      send_candidate(random_candidate($urandom_range(99) < 20, 1'b0));
  endtask

  task automatic run_directed();
    program_reference(DIR_UP, 0, 0, 10, 10);
    // lone candidate behind the reference: nothing found
    send_candidate(cand(0, 20, 4, 4, 0, 1));
    // field extremes, side miss, equal gaps decided by overlap, skipped winners
    send_candidate(cand(-32768, -32768, 65535, 65535, 0, 0));
    send_candidate(cand(32767, 32767, 0, 0, 0, 0));
    send_candidate(cand(-32768, -32768, 0, 0, 0, 0));
    send_candidate(cand(20, -20, 5, 5, 0, 0));
    send_candidate(cand(2, -10, 4, 5, 0, 0));
    send_candidate(cand(0, -10, 8, 5, 0, 0));
    send_candidate(cand(5, -10, 2, 5, 0, 0));
    send_candidate(cand(0, 0, 10, 10, 1, 0));
    send_candidate(cand(0, -10, 10, 5, 1, 1));
    // query made of one skipped candidate
    send_candidate(cand(0, 0, 0, 0, 1, 1));
    program_reference(DIR_DOWN, 0, 0, 10, 10);
    send_candidate(cand(0, 10, 10, 4, 0, 0));
    send_candidate(cand(3, 30, 2, 2, 0, 1));
    program_reference(DIR_LEFT, 0, 0, 10, 10);
    send_candidate(cand(-20, 0, 5, 10, 0, 0));
    send_candidate(cand(-5, 20, 5, 5, 0, 1));
    program_reference(DIR_RIGHT, 0, 0, 10, 10);
    send_candidate(cand(15, 2, 3, 3, 0, 0));
    send_candidate(cand(12, 1, 3, 3, 0, 1));
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    run_phase(DIR_UP, 100, -50, 20, 12, 0, 0, 150, 1'b1, 1'b0);
    run_phase(DIR_DOWN, -32768, -32768, 65535, 65535, 73, 0, 120, 1'b0, 1'b0);
    run_phase(DIR_LEFT, 32767, 32767, 0, 0, 0, 73, 120, 1'b0, 1'b0);
    run_phase(DIR_RIGHT, -7, 3, 9, 30, 38, 38, 150, 1'b1, 1'b0);
    run_phase(DIR_UP, int'($urandom_range(400)) - 200, int'($urandom_range(400)) - 200,
              $urandom_range(2, 40), $urandom_range(2, 40), 0, 0, 80, 1'b0, 1'b0);
    // result side held off while short queries keep coming
    run_phase(DIR_DOWN, int'($urandom_range(400)) - 200, int'($urandom_range(400)) - 200,
              $urandom_range(2, 40), $urandom_range(2, 40), 0, 0, 80, 1'b0, 1'b1);
    run_phase(DIR_LEFT, int'($urandom_range(400)) - 200, int'($urandom_range(400)) - 200,
              $urandom_range(2, 40), $urandom_range(2, 40), 73, 0, 80, 1'b0, 1'b0);
    run_phase(DIR_RIGHT, int'($urandom_range(400)) - 200, int'($urandom_range(400)) - 200,
              $urandom_range(2, 40), $urandom_range(2, 40), 38, 38, 80, 1'b0, 1'b0);
    settle_block();
    if (board.failures == 0 && board.pending() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

@@ directional_nearest_rect_select_core.f @@
hw/rtl/dnrs_pkg.sv
hw/rtl/directional_nearest_rect_select_core.sv
sim/tb_directional_nearest_rect_select_core.sv
